// File: sv/cln_pkg.sv
// Shared types, codes and tables for the character LCD nibble command sequencer.
// Used by the front end, the job queue, the back end and the top level.
package cln_pkg;

	// Command codes
	localparam logic [2:0] OP_PUT_CHAR = 3'd0;
	localparam logic [2:0] OP_RAW      = 3'd1;
	localparam logic [2:0] OP_GOTO     = 3'd2;
	localparam logic [2:0] OP_CLEAR    = 3'd3;
	localparam logic [2:0] OP_INIT     = 3'd4;
	localparam logic [2:0] OP_DETECT   = 3'd5;

	// Result kinds
	localparam logic [2:0] KIND_XFER   = 3'd0;
	localparam logic [2:0] KIND_W40MS  = 3'd1;
	localparam logic [2:0] KIND_W39US  = 3'd2;
	localparam logic [2:0] KIND_W37US  = 3'd3;
	localparam logic [2:0] KIND_POLL   = 3'd4;
	localparam logic [2:0] KIND_W153MS = 3'd5;

	// Instruction bytes
	localparam logic [7:0] INSTR_CLEAR = 8'h01;

	// Init run length and step counter width
	localparam int INIT_STEPS = 43;
	localparam int STEP_W     = $clog2(INIT_STEPS);
	localparam logic [STEP_W-1:0] INIT_LAST_STEP = STEP_W'(INIT_STEPS - 1);

	// Job queue depth
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [2:0] op;
		logic [7:0] data_byte;
		logic [2:0] row;
		logic [5:0] column;
		logic       detect_pin;
	} cln_cmd_t;

	typedef struct packed {
		logic [2:0] kind;
		logic       reg_select;
		logic [3:0] nibble;
		logic       last;
	} cln_res_t;

	// One classified command: either the init run or a byte with an optional tail
	typedef struct packed {
		logic       init;
		logic [7:0] data;
		logic       rs;
		logic       tail_en;
		logic [2:0] tail_kind;
	} cln_job_t;

	typedef struct packed {
		logic              busy;
		logic              init;
		logic [STEP_W-1:0] step;
	} cln_back_stat_t;

	// DDRAM base address of a display row
	function automatic logic [7:0] row_base(input logic [1:0] row);
		logic [7:0] base;
		unique case (row)
			2'd0: base = 8'h80;
			2'd1: base = 8'hC0;
			2'd2: base = 8'h94;
			default: base = 8'hD4;
		endcase
		return base;
	endfunction

	// Result of one step of the power-up run (last flag set by the caller)
	function automatic cln_res_t init_step(input logic [STEP_W-1:0] idx);
		cln_res_t r;
		r = '0;
		r.kind = KIND_XFER;
		unique case (idx)
			6'd0:                                   r.kind = KIND_W40MS;
			6'd3, 6'd6, 6'd9:                       r.kind = KIND_W39US;
			6'd12, 6'd15:                           r.kind = KIND_W37US;
			6'd18, 6'd21, 6'd24, 6'd27, 6'd30, 6'd33, 6'd36, 6'd39, 6'd42:
				r.kind = KIND_POLL;
			6'd1, 6'd4, 6'd7:                       r.nibble = 4'h3;
			6'd2, 6'd5, 6'd8, 6'd11, 6'd14, 6'd17, 6'd20, 6'd40:
				r.nibble = 4'h8;
			6'd10, 6'd13, 6'd16, 6'd19:             r.nibble = 4'h2;
			6'd22, 6'd25, 6'd28, 6'd31, 6'd34, 6'd37, 6'd41:
				r.nibble = 4'h0;
			6'd23, 6'd26:                           r.nibble = 4'hC;
			6'd29, 6'd32:                           r.nibble = 4'h1;
			6'd35, 6'd38:                           r.nibble = 4'h6;
			default:                                r.kind = KIND_POLL;
		endcase
		return r;
	endfunction

endpackage

// File: sv/char_lcd_nibble_command_sequencer.sv
// Top level of the character LCD nibble command sequencer: front end,
// job queue and back end. Depends on cln_pkg, cln_front, cln_queue, cln_back.
//
//   channel   handshake          payload      direction
//   command   push / full        cmd          in
//   result    empty / pop        res          out
//
// One result leaves per cycle while results are popped: put char, goto and
// clear give 3 results, a raw instruction 2, init 43, one per back end step.
// The front end takes one command per cycle while the 4-entry job queue has room;
// commands that give no results push no job.
// Reset clears the queue, the back end and the detect history; no clearing pass.
// A stalled result holds in the output register while the queue keeps filling.
module char_lcd_nibble_command_sequencer
	import cln_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	output logic     full,
	input  cln_cmd_t cmd,
	output logic     empty,
	input  logic     pop,
	output cln_res_t res
);

	logic              accept;
	logic              job_push;
	cln_job_t          job;
	logic              q_valid;
	cln_job_t          q_head;
	logic              q_pop;
	logic [QCNT_W-1:0] q_count;
	cln_back_stat_t    stat;

	assign accept = push && !full;

	cln_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.cmd      (cmd),
		.job_push (job_push),
		.job      (job)
	);

	cln_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.wdata  (job),
		.full   (full),
		.valid  (q_valid),
		.head   (q_head),
		.pop    (q_pop),
		.count  (q_count)
	);

	cln_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_head  (q_head),
		.q_pop   (q_pop),
		.empty   (empty),
		.res     (res),
		.pop     (pop),
		.stat    (stat)
	);

	// Queue never overfills
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= QCNT_W'(QUEUE_DEPTH))
		else $error("job queue count beyond depth");

	// Back end takes a job only from a non-empty queue
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("job taken from empty queue");

	// A byte job never runs past its tail step
	a_byte_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(stat.busy && !stat.init) |-> (stat.step <= STEP_W'(2)))
		else $error("byte job step out of range");

	// The init run never runs past its last step
	a_init_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(stat.busy && stat.init) |-> (stat.step <= INIT_LAST_STEP))
		else $error("init step out of range");

endmodule

// File: sv/cln_front.sv
// Front end: accepts commands, tracks the detect pin and classifies each
// command into a job for the queue. Depends on cln_pkg.
module cln_front
	import cln_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     accept,
	input  cln_cmd_t cmd,
	output logic     job_push,
	output cln_job_t job
);

	logic det_q;
	logic produce;

	// Classify the command
	always_comb begin
		produce       = 1'b0;
		job           = '0;
		job.data      = cmd.data_byte;
		job.tail_kind = KIND_POLL;
		unique case (cmd.op)
			OP_PUT_CHAR: begin
				produce     = 1'b1;
				job.rs      = 1'b1;
				job.tail_en = 1'b1;
			end
			OP_RAW: begin
				produce = 1'b1;
			end
			OP_GOTO: begin
				produce     = (cmd.row[2] == 1'b0);
				job.data    = row_base(cmd.row[1:0]) + {2'b00, cmd.column};
				job.tail_en = 1'b1;
			end
			OP_CLEAR: begin
				produce       = 1'b1;
				job.data      = INSTR_CLEAR;
				job.tail_en   = 1'b1;
				job.tail_kind = KIND_W153MS;
			end
			OP_INIT: begin
				produce  = 1'b1;
				job.init = 1'b1;
			end
			OP_DETECT: begin
				produce  = cmd.detect_pin && !det_q;
				job.init = 1'b1;
			end
			default: begin
				produce = 1'b0;
			end
		endcase
	end

	assign job_push = accept && produce;

	// Hold the last sampled detect level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			det_q <= 1'b0;
		end else if (accept && (cmd.op == OP_INIT || cmd.op == OP_DETECT)) begin
			det_q <= cmd.detect_pin;
		end
	end

endmodule

// File: sv/cln_queue.sv
// Short job queue between the front end and the back end.
// Depends on cln_pkg for the job type and depth.
module cln_queue
	import cln_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  cln_job_t          wdata,
	output logic              full,
	output logic              valid,
	output cln_job_t          head,
	input  logic              pop,
	output logic [QCNT_W-1:0] count
);

	cln_job_t          mem [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push;
	logic              do_pop;

	assign full    = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign valid   = (cnt_q != '0);
	assign head    = mem[rd_ptr_q];
	assign count   = cnt_q;
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	// Write storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= wdata;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

endmodule

// File: sv/cln_back.sv
// Back end: expands each job into bus phases and waits, one result per cycle
// into a free or popped output register. Needs cln_pkg types and init table.
module cln_back
	import cln_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  cln_job_t       q_head,
	output logic           q_pop,
	output logic           empty,
	output cln_res_t       res,
	input  logic           pop,
	output cln_back_stat_t stat
);

	cln_job_t          job_q;
	logic              busy_q;
	logic [STEP_W-1:0] step_q;
	cln_res_t          out_q;
	logic              out_v_q;
	cln_res_t          cur;
	logic              cur_last;
	logic              adv;

	// Form the result of the current step
	always_comb begin
		cur      = '0;
		cur_last = 1'b0;
		if (job_q.init) begin
			cur      = init_step(step_q);
			cur_last = (step_q == INIT_LAST_STEP);
		end else begin
			unique case (step_q)
				STEP_W'(0): begin
					cur.kind       = KIND_XFER;
					cur.reg_select = job_q.rs;
					cur.nibble     = job_q.data[7:4];
				end
				STEP_W'(1): begin
					cur.kind       = KIND_XFER;
					cur.reg_select = job_q.rs;
					cur.nibble     = job_q.data[3:0];
					cur_last       = !job_q.tail_en;
				end
				default: begin
					cur.kind = job_q.tail_kind;
					cur_last = 1'b1;
				end
			endcase
		end
		cur.last = cur_last;
	end

	assign adv   = busy_q && (!out_v_q || pop);
	assign q_pop = q_valid && (!busy_q || (adv && cur_last));

	// Load the next job, advance the step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			step_q  <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (q_pop) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (adv) begin
				if (cur_last) begin
					busy_q <= 1'b0;
				end else begin
					step_q <= step_q + STEP_W'(1);
				end
			end
			if (adv) begin
				out_v_q <= 1'b1;
			end else if (pop) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// Hold payload
	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q <= q_head;
		end
		if (adv) begin
			out_q <= cur;
		end
	end

	assign empty     = !out_v_q;
	assign res       = out_q;
	assign stat.busy = busy_q;
	assign stat.init = job_q.init;
	assign stat.step = step_q;

endmodule
